// ===== src/hal_pkg.sv =====
// Package with shared types and constants of the heading acquire and latch block.
package hal_pkg;

  // Width of the frame counters and their saturation value.
  localparam int unsigned CountW   = 6;
  localparam logic [CountW-1:0] CountMax = '1;

  // Width of the register fields on the configuration port.
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CfgAddrW-1:0] {
    RegLatchEnable      = 3'd0,
    RegAcquireTolerance = 3'd1,
    RegAnomalyThreshold = 3'd2,
    RegFramesToLatch    = 3'd3,
    RegAnomalyCap       = 3'd4
  } hal_reg_e;

  // Input command codes.
  localparam logic FuncObserve = 1'b0;
  localparam logic FuncUnlatch = 1'b1;

  // One result item, last field in the lowest bits.
  typedef struct packed {
    logic [CountW-1:0] confirm_frames;
    logic [CountW-1:0] anomaly_frames;
    logic [15:0]       deviation;
    logic [15:0]       held_heading;
    logic              is_latched;
    logic              newly_latched;
  } hal_result_t;

  localparam int unsigned ResultW    = $bits(hal_result_t);
  localparam int unsigned OutTdataW  = ((ResultW + 7) / 8) * 8;
  localparam int unsigned OutPadW    = OutTdataW - ResultW;

endpackage

// ===== src/hal_core.sv =====
// Heading state, configuration registers and the per-sample update logic.
module hal_core #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [hal_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [hal_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                     item_en_i,
  input  logic                     func_i,
  input  logic [15:0]              yaw_angle_i,
  input  logic                     yaw_valid_i,
  output hal_pkg::hal_result_t     result_o
);
  import hal_pkg::*;

  localparam int unsigned A     = ANGLE_BITS;
  localparam int unsigned WideW = (A > 16) ? A : 16;

  // Configuration registers.
  logic              latch_enable_q;
  logic [15:0]       acq_tol_q;
  logic [15:0]       anom_thr_q;
  logic [CountW-1:0] frames_q;
  logic [CountW-1:0] anom_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_enable_q <= 1'b1;
      acq_tol_q      <= 16'd364;
      anom_thr_q     <= 16'd1820;
      frames_q       <= CountW'(6);
      anom_cap_q     <= CountW'(3);
    end else if (cfg_valid_i) begin
      case (hal_reg_e'(cfg_addr_i))
        RegLatchEnable:      latch_enable_q <= cfg_wdata_i[0];
        RegAcquireTolerance: acq_tol_q      <= cfg_wdata_i;
        RegAnomalyThreshold: anom_thr_q     <= cfg_wdata_i;
        RegFramesToLatch:    frames_q       <= cfg_wdata_i[CountW-1:0];
        RegAnomalyCap:       anom_cap_q     <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Heading state.
  logic              latched_q, latched_d;
  logic [A-1:0]      heading_q, heading_d;
  logic [A-1:0]      cand_q, cand_d;
  logic [CountW-1:0] cons_q, cons_d;
  logic [CountW-1:0] anom_q, anom_d;
  logic [A-1:0]      dev_q, dev_d;
  logic [CountW-1:0] confirm_q, confirm_d;
  logic              fresh;

  // Sample sign extended to at least 16 bits, then truncated to the angle width.
  logic [WideW-1:0] ang_wide;
  logic [A-1:0]     ang;
  assign ang_wide = WideW'($signed(yaw_angle_i));
  assign ang      = ang_wide[A-1:0];

  // Wrapped difference to the candidate and its magnitude.
  logic [A-1:0] cdiff, cmag;
  logic         cneg;
  logic [A:0]   cround;
  logic [A-1:0] cstep;
  logic         consistent;
  assign cdiff      = ang - cand_q;
  assign cneg       = cdiff[A-1];
  assign cmag       = cneg ? (~cdiff + A'(1)) : cdiff;
  assign cround     = {1'b0, cmag} + (A+1)'(2);
  assign cstep      = A'(cround[A:2]);
  assign consistent = (cons_q != '0) && (WideW'(cmag) <= WideW'(acq_tol_q));

  // Wrapped deviation from the held heading.
  logic [A-1:0] hdiff, hmag;
  assign hdiff = ang - heading_q;
  assign hmag  = hdiff[A-1] ? (~hdiff + A'(1)) : hdiff;

  logic [CountW-1:0] cap_eff;
  logic [CountW:0]   anom_inc;
  assign cap_eff  = (anom_cap_q == '0) ? CountW'(1) : anom_cap_q;
  assign anom_inc = {1'b0, anom_q} + (CountW+1)'(1);

  always_comb begin
    latched_d = latched_q;
    heading_d = heading_q;
    cand_d    = cand_q;
    cons_d    = cons_q;
    anom_d    = anom_q;
    dev_d     = dev_q;
    confirm_d = confirm_q;
    fresh     = 1'b0;
    if (func_i == FuncUnlatch) begin
      if (latched_q || cons_q != '0) begin
        latched_d = 1'b0;
        cand_d    = '0;
        cons_d    = '0;
        anom_d    = '0;
        dev_d     = '0;
        confirm_d = '0;
      end
    end else if (latch_enable_q && yaw_valid_i) begin
      if (!latched_q) begin
        if (consistent) begin
          cand_d = cneg ? (cand_q - cstep) : (cand_q + cstep);
          cons_d = (cons_q == CountMax) ? cons_q : cons_q + CountW'(1);
        end else begin
          cand_d = ang;
          cons_d = CountW'(1);
        end
        if (cons_d >= frames_q) begin
          latched_d = 1'b1;
          heading_d = cand_d;
          confirm_d = cons_d;
          fresh     = 1'b1;
        end
      end else begin
        dev_d = hmag;
        if (WideW'(hmag) > WideW'(anom_thr_q)) begin
          anom_d = (anom_inc < {1'b0, cap_eff}) ? anom_inc[CountW-1:0] : cap_eff;
        end else begin
          anom_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= 1'b0;
      heading_q <= '0;
      cand_q    <= '0;
      cons_q    <= '0;
      anom_q    <= '0;
      dev_q     <= '0;
      confirm_q <= '0;
    end else if (item_en_i) begin
      latched_q <= latched_d;
      heading_q <= heading_d;
      cand_q    <= cand_d;
      cons_q    <= cons_d;
      anom_q    <= anom_d;
      dev_q     <= dev_d;
      confirm_q <= confirm_d;
    end
  end

  // Result fields reflect the state after this item.
  logic [WideW-1:0] heading_wide, dev_wide;
  assign heading_wide = latched_d ? WideW'(heading_d) : '0;
  assign dev_wide     = WideW'(dev_d);

  always_comb begin
    result_o.newly_latched  = fresh;
    result_o.is_latched     = latched_d;
    result_o.held_heading   = heading_wide[15:0];
    result_o.deviation      = dev_wide[15:0];
    result_o.anomaly_frames = anom_d;
    result_o.confirm_frames = confirm_d;
  end

endmodule

// ===== src/hal_skid.sv =====
// Two-entry result buffer: output register plus skid register.
module hal_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hal_pkg::hal_result_t push_data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 pop_ready_i,
  output hal_pkg::hal_result_t data_o
);
  import hal_pkg::*;

  logic        out_valid_q, skid_valid_q;
  hal_result_t out_data_q, skid_data_q;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop_ready_i) begin
      out_data_q <= skid_valid_q ? skid_data_q : push_data_i;
    end else if (push_i) begin
      skid_data_q <= push_data_i;
    end
  end

endmodule

// ===== src/heading_acquire_and_latch.sv =====
// Top level of the heading acquire and latch block.
// Heading samples arrive as signed binary angles on the slave stream, one transaction per
// sample, and every transaction yields exactly one result transaction on the master
// stream. The block takes one transaction per clock cycle while tready is high; its
// result is registered; the update (wrapped subtract, magnitude, rounded quarter step,
// tolerance compare and counter update) is one pass of logic between the heading state
// registers and a two-entry result buffer. That buffer (output register plus skid
// register) lets the slave side keep accepting while a result waits on the master side;
// tready only drops once both entries hold unclaimed results. Before latching, the block
// tracks a candidate heading and counts consistent samples; once the count reaches
// frames_to_latch the candidate becomes the held heading. While latched, each sample
// reports its absolute wrapped deviation and a saturating anomaly count. An unlatch
// command (tuser func bit set) clears acquisition and monitoring. Samples flagged invalid
// or arriving with latch_enable cleared leave the state untouched but still produce a
// result. Configuration writes are always accepted and must only be issued while the
// block is idle. Internally angles are ANGLE_BITS wide, with a full turn of
// 2^ANGLE_BITS units; the 16-bit port sample is sign extended or truncated to that width.
module heading_acquire_and_latch #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hal_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [hal_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Sample stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [15:0]                   s_axis_tdata_i,  // [15:0] yaw_angle
  input  logic [1:0]                    s_axis_tuser_i,  // [0] func, [1] yaw_valid
  // Result stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] newly_latched, [1] is_latched, [17:2] held_heading, [33:18] deviation,
  // [39:34] anomaly_frames, [45:40] confirm_frames, [47:46] zero
  output logic [hal_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import hal_pkg::*;

  logic        accept;
  logic        buf_ready;
  hal_result_t result;
  hal_result_t out_result;

  // The configuration port never stalls.
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = buf_ready;
  assign accept          = s_axis_tvalid_i && buf_ready;

  hal_core #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_en_i   (accept),
    .func_i      (s_axis_tuser_i[0]),
    .yaw_angle_i (s_axis_tdata_i),
    .yaw_valid_i (s_axis_tuser_i[1]),
    .result_o    (result)
  );

  // Results are buffered so the sample side is decoupled from the result side.
  hal_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (out_result)
  );

  assign m_axis_tdata_o = {{OutPadW{1'b0}}, out_result};

endmodule

// ===== src/hal_checker.sv =====
// Port-level checker for the heading acquire and latch block, with its bind.
module hal_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [hal_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import hal_pkg::*;

  hal_result_t res;
  assign res = hal_result_t'(m_axis_tdata_o[ResultW-1:0]);

  // A result that waits keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // A fresh latch is always reported as latched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.newly_latched |-> res.is_latched)
    else $error("newly_latched without is_latched");

  // Without a latch, no heading, deviation or counts are reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !res.is_latched |->
      res.held_heading == '0 && res.deviation == '0 &&
      res.anomaly_frames == '0 && res.confirm_frames == '0)
    else $error("unlatched result carries stale state");

  // A latched result always records a nonzero confirmation count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.is_latched |-> res.confirm_frames != '0)
    else $error("latched with zero confirmation count");

endmodule

bind heading_acquire_and_latch hal_checker u_hal_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
